// ===== src/bdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpc_pkg: shared definitions for the button debounce and press classifier
// Field widths, register indexes and event codes used by the block and its
// stream payload layout.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned EventW    = 2;
  localparam int unsigned FsmW      = 3;
  localparam int unsigned InDataW   = 40;  // 1 + 32 bits, padded to bytes
  localparam int unsigned OutDataW  = 8;   // 2 + 3 + 1 bits, padded to bytes

  // register indexes
  localparam logic [CfgIdxW-1:0] RegDebounce  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegLongPress = 8'd1;

  // reset values
  localparam logic [CfgW-1:0] DebounceReset  = 16'd50;
  localparam logic [CfgW-1:0] LongPressReset = 16'd1000;

  // event codes
  typedef enum logic [EventW-1:0] {
    EV_NONE     = 2'd0,
    EV_SHORT    = 2'd1,
    EV_LONG     = 2'd2,
    EV_RELEASED = 2'd3
  } event_t;

endpackage

// ===== src/button_debounce_press_classifier.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_classifier: debounce and short/long press detection
// Five-state machine over timestamped pin samples, one result per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transaction per pin sample. tdata carries raw_level in
//   bit 0 and the 32-bit millisecond timestamp now_ms in bits 32:1.
//   Master stream: exactly one transaction per accepted sample, in order.
//   tdata carries event_code [1:0], fsm_code [4:2], accepted_level [5].
//   Config port: cfg_we writes cfg_data into register cfg_index
//   (0 debounce_ms, 1 long_press_ms); other indexes are ignored. Write only
//   while the block is idle.
// Timing and throughput:
//   The result of a sample is visible on the master side in the cycle after
//   it is accepted. One sample per cycle is sustained while m_tready stays
//   high: the machine state and the output register both update at the
//   accepting edge, set by a 32-bit timestamp subtract and compare per path.
// Reset (rst, synchronous): machine idle, accepted level low, stamps zero,
//   debounce_ms = 50, long_press_ms = 1000, output register empty.
// Stall: when the receiver holds tready low with a result waiting, s_tready
//   drops in the same cycle; it returns as soon as the waiting result is
//   taken, so a result being drained and a new sample move in the same cycle.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier (
  input  logic                           clk,
  input  logic                           rst,
  // sample stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bdpc_pkg::InDataW-1:0]   s_tdata,   // raw_level, now_ms
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bdpc_pkg::OutDataW-1:0]  m_tdata,   // event_code, fsm_code, accepted_level
  // configuration
  input  logic                           cfg_we,
  input  logic [bdpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bdpc_pkg::CfgW-1:0]      cfg_data
);
  import bdpc_pkg::*;

  typedef enum logic [FsmW-1:0] {
    ST_IDLE     = 3'd0,
    ST_DEBOUNCE = 3'd1,
    ST_PRESSED  = 3'd2,
    ST_LONG     = 3'd3,
    ST_RELEASED = 3'd4
  } state_t;

  // registers
  logic [CfgW-1:0]  debounce_ms;
  logic [CfgW-1:0]  long_press_ms;
  state_t           state;
  logic             stable_level;
  logic [TimeW-1:0] change_stamp;
  logic [TimeW-1:0] press_stamp;
  logic             out_valid;
  event_t           out_event;
  state_t           out_state;
  logic             out_level;

  // next values
  state_t           state_next;
  logic             stable_level_next;
  logic [TimeW-1:0] change_stamp_next;
  logic [TimeW-1:0] press_stamp_next;
  event_t           event_next;

  logic             in_level;
  logic [TimeW-1:0] in_now;
  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] held;
  logic             accept;

  assign in_level = s_tdata[0];
  assign in_now   = s_tdata[TimeW:1];

  // output register is free when empty or being drained this cycle
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // differences wrap modulo 2^32
  assign since_change = in_now - change_stamp;
  assign held         = in_now - press_stamp;

  always_comb begin
    state_next        = state;
    stable_level_next = stable_level;
    change_stamp_next = change_stamp;
    press_stamp_next  = press_stamp;
    event_next        = EV_NONE;
    case (state)
      ST_DEBOUNCE: begin
        if (since_change >= {{(TimeW-CfgW){1'b0}}, debounce_ms}) begin
          // window over: take the new level, or fall back if it bounced back
          state_next = ST_IDLE;
          if (in_level != stable_level) begin
            stable_level_next = in_level;
            if (in_level) begin
              press_stamp_next = in_now;
              state_next       = ST_PRESSED;
            end
          end
        end
      end
      ST_PRESSED: begin
        if (!in_level) begin
          // release below the threshold is a short press; past it but not yet reported: no event
          if (held < {{(TimeW-CfgW){1'b0}}, long_press_ms}) begin
            event_next = EV_SHORT;
          end
          state_next = ST_RELEASED;
        end else if (held >= {{(TimeW-CfgW){1'b0}}, long_press_ms}) begin
          event_next = EV_LONG;
          state_next = ST_LONG;
        end
      end
      ST_LONG: begin
        if (!in_level) begin
          state_next = ST_RELEASED;
        end
      end
      ST_RELEASED: begin
        event_next = EV_RELEASED;
        state_next = ST_IDLE;
      end
      default: begin
        // idle, and any stray code behaves as idle
        if (in_level != stable_level) begin
          change_stamp_next = in_now;
          state_next        = ST_DEBOUNCE;
        end else begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DebounceReset;
      long_press_ms <= LongPressReset;
      state         <= ST_IDLE;
      stable_level  <= 1'b0;
      change_stamp  <= '0;
      press_stamp   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegDebounce:  debounce_ms   <= cfg_data;
          RegLongPress: long_press_ms <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        state        <= state_next;
        stable_level <= stable_level_next;
        change_stamp <= change_stamp_next;
        press_stamp  <= press_stamp_next;
        out_valid    <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on every accepted sample
  always_ff @(posedge clk) begin
    if (accept) begin
      out_event <= event_next;
      out_state <= state_next;
      out_level <= stable_level_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataW-EventW-FsmW-1){1'b0}}, out_level, out_state, out_event};

  // a sample taken in the released state yields a release event next cycle
  a_release_follows: assert property (@(posedge clk) disable iff (rst)
    accept && state == ST_RELEASED |=> m_tvalid && out_event == EV_RELEASED
                                       && out_state == ST_IDLE)
    else $error("release event missing after released state");

  // short press is only reported on entry to released
  a_short_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_event == EV_SHORT |-> out_state == ST_RELEASED)
    else $error("short press without released state");

  // long press is only reported on entry to long state
  a_long_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_event == EV_LONG |-> out_state == ST_LONG)
    else $error("long press without long state");

  // a press is only held with a high accepted level
  a_press_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_state == ST_PRESSED || out_state == ST_LONG) |-> out_level)
    else $error("press state with low accepted level");

  // machine state follows the registered result
  a_state_match: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == out_state && stable_level == out_level)
    else $error("result register out of step with machine state");

endmodule
